// File: rtl/core/swa_pkg.sv
// Shared types and constants for the sensor window aggregator.
// Used by every module in rtl/core; depends on nothing.
package swa_pkg;

    // Fixed field widths.
    localparam int TICK_W   = 6;
    localparam int TEMP_W   = 16;
    localparam int SUM_W    = 21;
    localparam int COUNT_W  = 6;
    localparam int VOLT_W   = 16;
    localparam int MASK_W   = 3;
    localparam int SEQ_W    = 16;
    localparam int RNUM_W   = 3;
    localparam int RCNT_W   = 4;
    localparam int IVAL_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 136;

    // Default window length.
    localparam int WINDOW_TICKS_DEF = 30;

    // Voltage capture slot bounds.
    localparam logic [TICK_W-1:0] SLOT_FIRST_LO  = 6'd10;
    localparam logic [TICK_W-1:0] SLOT_FIRST_HI  = 6'd15;
    localparam logic [TICK_W-1:0] SLOT_SECOND_LO = 6'd20;
    localparam logic [TICK_W-1:0] SLOT_SECOND_HI = 6'd25;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETX_INTERVAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETX_LIMIT     = 2'd2;

    // Configuration reset values.
    localparam logic [VOLT_W-1:0] VOLT_THRESHOLD_RST = 16'd3000;
    localparam logic [IVAL_W-1:0] RETX_INTERVAL_RST  = 5'd10;
    localparam logic [RNUM_W-1:0] RETX_LIMIT_RST     = 3'd3;

    // Window reset values for the temperature extremes.
    localparam logic signed [TEMP_W-1:0] TEMP_MIN_RST = 16'sh7FFF;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX_RST = 16'sh8000;

    // Statistics of one window.
    typedef struct packed {
        logic signed [SUM_W-1:0]  sum;
        logic [COUNT_W-1:0]       count;
        logic signed [TEMP_W-1:0] tmin;
        logic signed [TEMP_W-1:0] tmax;
        logic [MASK_W-1:0]        mask;
        logic [VOLT_W-1:0]        volt_first;
        logic [VOLT_W-1:0]        volt_second;
        logic [VOLT_W-1:0]        volt_third;
    } win_rec_t;

    // One input tick after unpacking.
    typedef struct packed {
        logic                     temp_valid;
        logic signed [TEMP_W-1:0] temperature;
        logic                     volt_valid;
        logic [VOLT_W-1:0]        battery_mv;
    } tick_in_t;

    // Status handed from the window accumulator to the scheduler.
    typedef struct packed {
        logic [TICK_W-1:0] tick;
        logic              window_end;
        win_rec_t          rec_next;
    } win_status_t;

    // One result item.
    typedef struct packed {
        logic              last;
        logic [RNUM_W-1:0] retx_num;
        logic [SEQ_W-1:0]  packet_seq;
        win_rec_t          rec;
    } result_t;

endpackage

// File: rtl/core/swa_window.sv
// Window accumulator: tick counter, temperature statistics and voltage snapshots.
// Depends on swa_pkg.
module swa_window
    import swa_pkg::*;
#(
    parameter int WINDOW_TICKS = WINDOW_TICKS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  tick_in_t    tick_in,
    output win_status_t status
);

    localparam logic [TICK_W-1:0] LAST_TICK = TICK_W'(WINDOW_TICKS - 1);
    localparam logic signed [SUM_W:0] SUM_HI = (SUM_W+1)'(2**(SUM_W-1) - 1);
    localparam logic signed [SUM_W:0] SUM_LO = -(SUM_W+1)'(2**(SUM_W-1));

    logic [TICK_W-1:0]   tick_reg;
    win_rec_t            rec_reg;
    win_rec_t            rec_next;
    win_rec_t            rec_clear;
    logic                window_end;
    logic signed [SUM_W:0] sum_wide;

    // Values of an empty window.
    always_comb
    begin
        rec_clear             = '0;
        rec_clear.tmin        = TEMP_MIN_RST;
        rec_clear.tmax        = TEMP_MAX_RST;
    end

    assign window_end = (tick_reg >= LAST_TICK);

    // Statistics including the current tick.
    always_comb
    begin
        rec_next = rec_reg;
        sum_wide = {rec_reg.sum[SUM_W-1], rec_reg.sum}
                 + {{(SUM_W+1-TEMP_W){tick_in.temperature[TEMP_W-1]}}, tick_in.temperature};

        // Voltage snapshots.
        if (tick_in.volt_valid)
        begin
            if (tick_reg >= SLOT_FIRST_LO && tick_reg <= SLOT_FIRST_HI && !rec_reg.mask[0])
            begin
                rec_next.volt_first = tick_in.battery_mv;
                rec_next.mask[0]    = 1'b1;
            end
            else if (tick_reg >= SLOT_SECOND_LO && tick_reg <= SLOT_SECOND_HI
                     && !rec_reg.mask[1])
            begin
                rec_next.volt_second = tick_in.battery_mv;
                rec_next.mask[1]     = 1'b1;
            end
            else if (tick_reg > SLOT_SECOND_HI)
            begin
                rec_next.volt_third = tick_in.battery_mv;
                rec_next.mask[2]    = 1'b1;
            end
        end

        // Temperature sum saturates at the signed field range.
        if (tick_in.temp_valid)
        begin
            if (sum_wide > SUM_HI)
                rec_next.sum = SUM_HI[SUM_W-1:0];
            else if (sum_wide < SUM_LO)
                rec_next.sum = SUM_LO[SUM_W-1:0];
            else
                rec_next.sum = sum_wide[SUM_W-1:0];
            rec_next.count = rec_reg.count + COUNT_W'(1);
            if (tick_in.temperature < rec_reg.tmin)
                rec_next.tmin = tick_in.temperature;
            if (tick_in.temperature > rec_reg.tmax)
                rec_next.tmax = tick_in.temperature;
        end
    end

    // Window registers; cleared after the last tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
            rec_reg  <= rec_clear;
        end
        else if (accept)
        begin
            if (window_end)
            begin
                tick_reg <= '0;
                rec_reg  <= rec_clear;
            end
            else
            begin
                tick_reg <= tick_reg + TICK_W'(1);
                rec_reg  <= rec_next;
            end
        end
    end

    assign status.tick       = tick_reg;
    assign status.window_end = window_end;
    assign status.rec_next   = rec_next;

endmodule

// File: rtl/core/swa_sched.sv
// Transmission scheduler: configuration, sent record, retransmission budget
// and packet number; forms up to two results per tick. Depends on swa_pkg.
module swa_sched
    import swa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    input  tick_in_t              tick_in,
    input  win_status_t           status,
    output logic [1:0]            push_num,
    output result_t               push_first,
    output result_t               push_second
);

    localparam int IVAL_NUM = 2**IVAL_W;
    localparam int TICK_NUM = 2**TICK_W;

    // Ticks at which a retransmission may happen for a given interval:
    // every tick but the first whose index is one short of a multiple.
    function automatic logic [TICK_NUM-1:0] retx_slots(input logic [IVAL_W-1:0] d);
        logic [TICK_NUM-1:0] m;
        logic [TICK_W-1:0]   c;
        logic [TICK_W-1:0]   top;
        m   = '0;
        c   = '0;
        top = TICK_W'(d) - TICK_W'(1);
        if (d != '0)
        begin
            for (int n = 0; n < TICK_NUM; n++)
            begin
                if (n != 0 && c == top)
                    m[n] = 1'b1;
                if (c == top)
                    c = '0;
                else
                    c = c + TICK_W'(1);
            end
        end
        return m;
    endfunction

    logic [TICK_NUM-1:0] slot_tbl [IVAL_NUM];

    genvar g;
    generate
        for (g = 0; g < IVAL_NUM; g++)
        begin : g_slot
            assign slot_tbl[g] = retx_slots(IVAL_W'(g));
        end
    endgenerate

    logic [VOLT_W-1:0] threshold_reg;
    logic [IVAL_W-1:0] interval_reg;
    logic [RNUM_W-1:0] limit_reg;
    win_rec_t          sent_reg;
    logic [RCNT_W-1:0] retx_cnt_reg;
    logic [SEQ_W-1:0]  seq_reg;

    logic              retx_go;
    logic [SEQ_W-1:0]  seq_next;
    result_t           retx_res;
    result_t           new_res;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= VOLT_THRESHOLD_RST;
            interval_reg  <= RETX_INTERVAL_RST;
            limit_reg     <= RETX_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_VOLT_THRESHOLD: threshold_reg <= cfg_data[VOLT_W-1:0];
                CFG_RETX_INTERVAL:  interval_reg  <= cfg_data[IVAL_W-1:0];
                CFG_RETX_LIMIT:     limit_reg     <= cfg_data[RNUM_W-1:0];
                default:            ;
            endcase
        end
    end

    // Retransmission needs the slot, remaining budget and a good battery.
    assign retx_go = slot_tbl[interval_reg][status.tick]
                   && (retx_cnt_reg < {1'b0, limit_reg})
                   && tick_in.volt_valid
                   && (tick_in.battery_mv > threshold_reg);

    assign seq_next = seq_reg + SEQ_W'(1);

    always_comb
    begin
        retx_res.last       = !status.window_end;
        retx_res.retx_num   = retx_cnt_reg[RNUM_W-1:0];
        retx_res.packet_seq = seq_reg;
        retx_res.rec        = sent_reg;

        new_res.last        = 1'b1;
        new_res.retx_num    = '0;
        new_res.packet_seq  = seq_next;
        new_res.rec         = status.rec_next;
    end

    // Results in order: retransmission of the old record first.
    always_comb
    begin
        push_first  = new_res;
        push_second = new_res;
        push_num    = 2'd0;
        if (accept)
        begin
            if (retx_go)
            begin
                push_first = retx_res;
                push_num   = status.window_end ? 2'd2 : 2'd1;
            end
            else if (status.window_end)
            begin
                push_num   = 2'd1;
            end
        end
    end

    // Sent record, budget counter and packet number.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg     <= '0;
            retx_cnt_reg <= RCNT_W'(RETX_LIMIT_RST) + RCNT_W'(1);
            seq_reg      <= '0;
        end
        else if (accept)
        begin
            if (status.window_end)
            begin
                sent_reg     <= status.rec_next;
                seq_reg      <= seq_next;
                retx_cnt_reg <= RCNT_W'(1);
            end
            else if (retx_go)
            begin
                retx_cnt_reg <= retx_cnt_reg + RCNT_W'(1);
            end
        end
    end

endmodule

// File: rtl/core/swa_out_fifo.sv
// Four-entry result queue taking up to two results per cycle, one out.
// Depends on swa_pkg.
module swa_out_fifo
    import swa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_num,
    input  result_t    push_first,
    input  result_t    push_second,
    output logic       room,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_item
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    result_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               pop;

    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // Room for two more results regardless of the output side.
    assign room      = (count_reg <= CNT_W'(DEPTH - 2));

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push_num != 2'd0)
            mem[wr_ptr_reg] <= push_first;
        if (push_num == 2'd2)
            mem[wr_ptr_reg + PTR_W'(1)] <= push_second;
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_num);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg  <= count_reg + CNT_W'(push_num) - CNT_W'(pop);
        end
    end

endmodule

// File: rtl/core/sensor_window_aggregator_top.sv
// A result enters the result queue with the transfer of its tick and is offered from its registers.
// Throughput: one tick per cycle while the result side keeps up; a window-end
// tick with a retransmission gives two results, which the four-entry result
// queue absorbs without stalling input.
// Reset: configuration returns to its defaults, the window and queue empty at once.
// Top level; depends on swa_pkg, swa_window, swa_sched and swa_out_fifo.
module sensor_window_aggregator_top
    import swa_pkg::*;
#(
    parameter int WINDOW_TICKS = WINDOW_TICKS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Tick stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // temperature, battery_mv
    input  logic [IN_USER_W-1:0]  s_axis_tuser,  // temp_valid, volt_valid
    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // retransmission_number, packet_seq, temp_sum, temp_count, temp_min,
    // temp_max, voltage_mask, volt_first, volt_second, volt_third, zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    localparam int PAYLOAD_W = RNUM_W + SEQ_W + SUM_W + COUNT_W + 2*TEMP_W + MASK_W + 3*VOLT_W;

    tick_in_t    tick_in;
    win_status_t status;
    logic        accept;
    logic [1:0]  push_num;
    result_t     push_first;
    result_t     push_second;
    result_t     out_item;

    // Unpack the input transfer.
    assign tick_in.temp_valid  = s_axis_tuser[0];
    assign tick_in.volt_valid  = s_axis_tuser[1];
    assign tick_in.temperature = s_axis_tdata[TEMP_W-1:0];
    assign tick_in.battery_mv  = s_axis_tdata[TEMP_W +: VOLT_W];

    assign accept = s_axis_tvalid && s_axis_tready;

    swa_window #(
        .WINDOW_TICKS (WINDOW_TICKS)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .tick_in (tick_in),
        .status  (status)
    );

    swa_sched u_sched (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .tick_in     (tick_in),
        .status      (status),
        .push_num    (push_num),
        .push_first  (push_first),
        .push_second (push_second)
    );

    swa_out_fifo u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_num    (push_num),
        .push_first  (push_first),
        .push_second (push_second),
        .room        (s_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_item    (out_item)
    );

    // Pack the result, first field in the lowest bits.
    assign m_axis_tlast = out_item.last;
    assign m_axis_tdata = {
        (OUT_DATA_W - PAYLOAD_W)'(0),
        out_item.rec.volt_third,
        out_item.rec.volt_second,
        out_item.rec.volt_first,
        out_item.rec.mask,
        out_item.rec.tmax,
        out_item.rec.tmin,
        out_item.rec.count,
        out_item.rec.sum,
        out_item.packet_seq,
        out_item.retx_num
    };

endmodule

// File: verif/sensor_window_aggregator_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sensor_window_aggregator_top: a table of directed
// windows, then random ticks under changing register settings and stalls.
// Depends on swa_pkg and the RTL under rtl/core; reads no files.
module sensor_window_aggregator_top_tb;
    import swa_pkg::*;

    localparam int TICKS_TARGET   = 1150;
    localparam int MAX_GAP        = 13;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 4;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int PRESSURE_PHASE = 6;
    localparam int SUM_HI         = 1048575;
    localparam int SUM_LO         = -1048576;
    localparam int WINDOW         = WINDOW_TICKS_DEF;

    // Directed rows: a run of identical ticks, a register write, or a single
    // tick whose final packet is typed in by hand.
    typedef enum {ROW_TICK, ROW_CFG, ROW_CHECKED} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   cidx;
        int                     cval;
        int                     tv;
        int                     temp;
        int                     vv;
        int                     mv;
        int                     reps;
        int                     e_seq;
        int                     e_sum;
        int                     e_cnt;
        int                     e_min;
        int                     e_max;
        int                     e_mask;
        int                     e_v1;
        int                     e_v2;
        int                     e_v3;
    } step_row_t;

    step_row_t dir_table [15] = '{
        // Power-up window: good voltage everywhere, no valid temperature.
        '{ROW_TICK, CFG_VOLT_THRESHOLD, 0, 0, -32768, 1, 65535, 10,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_RETX_LIMIT, 7, 0, 0, 0, 0, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_TICK, CFG_VOLT_THRESHOLD, 0, 0, 32767, 1, 65535, 19,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CHECKED, CFG_VOLT_THRESHOLD, 0, 0, 32767, 1, 65535, 1,
          1, 0, 0, 32767, -32768, 7, 65535, 65535, 65535},
        '{ROW_CFG, CFG_RETX_LIMIT, 3, 0, 0, 0, 0, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        // Full-scale window: half at the top of the range, half at the bottom.
        '{ROW_TICK, CFG_VOLT_THRESHOLD, 0, 1, 32767, 0, 0, 9,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_TICK, CFG_VOLT_THRESHOLD, 0, 1, 32767, 1, 3001, 1,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_TICK, CFG_VOLT_THRESHOLD, 0, 1, 32767, 1, 3000, 5,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_TICK, CFG_VOLT_THRESHOLD, 0, 1, -32768, 0, 0, 4,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_TICK, CFG_VOLT_THRESHOLD, 0, 1, -32768, 1, 3000, 1,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_TICK, CFG_VOLT_THRESHOLD, 0, 1, -32768, 0, 0, 9,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CHECKED, CFG_VOLT_THRESHOLD, 0, 1, -32768, 1, 65535, 1,
          2, -15, 30, -32768, 32767, 5, 3000, 0, 65535},
        // A zero interval gives no retransmission at all.
        '{ROW_CFG, CFG_RETX_INTERVAL, 0, 0, 0, 0, 0, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_TICK, CFG_VOLT_THRESHOLD, 0, 1, 100, 1, 65535, 30,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_RETX_INTERVAL, 10, 0, 0, 0, 0, 0,
          0, 0, 0, 0, 0, 0, 0, 0, 0}
    };

    int ival_picks [10] = '{0, 1, 2, 3, 5, 9, 10, 29, 30, 31};

    // Block ports.
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    // Shared control between the processes.
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int error_count = 0;
    int ticks_sent = 0;
    int packets_seen = 0;
    int retx_seen = 0;
    int reg_writes = 0;
    int cycle_count = 0;

    // Window predictor state and its copy of the registers.
    logic [VOLT_W-1:0]   pred_thr;
    logic [IVAL_W-1:0]   pred_ival;
    logic [RNUM_W-1:0]   pred_lim;
    int                  pred_tick;
    int                  acc_sum;
    logic [COUNT_W-1:0]  acc_count;
    int                  acc_min;
    int                  acc_max;
    logic [VOLT_W-1:0]   acc_volt [3];
    logic [MASK_W-1:0]   acc_mask;
    win_rec_t            held_rec;
    logic [RCNT_W-1:0]   retx_cnt;
    logic [SEQ_W-1:0]    seq_num;
    result_t             pending_packets [$];

    sensor_window_aggregator_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock generation.
    always #2 clk = ~clk;

    // Returns the window statistics to their empty values.
    task automatic open_window();
        acc_sum   = 0;
        acc_count = '0;
        acc_min   = 32767;
        acc_max   = -32768;
        acc_volt[0] = '0;
        acc_volt[1] = '0;
        acc_volt[2] = '0;
        acc_mask  = '0;
    endtask

    // Builds a packet carrying the held record.
    function automatic result_t held_packet(input logic [RNUM_W-1:0] num);
        result_t pkt;
        pkt.last       = 1'b0;
        pkt.retx_num   = num;
        pkt.packet_seq = seq_num;
        pkt.rec        = held_rec;
        return pkt;
    endfunction

    // Advances the window by one tick and queues the packets it causes.
    task automatic aggregate_tick(input logic tv, input logic signed [TEMP_W-1:0] temp,
                                  input logic vv, input logic [VOLT_W-1:0] mv);
        int      next_sum;
        int      ival;
        int      n;
        bit      opportunity;
        result_t made [2];
        n    = 0;
        ival = pred_ival;

        // Voltage snapshots come first.
        if (vv)
        begin
            if (pred_tick >= SLOT_FIRST_LO && pred_tick <= SLOT_FIRST_HI && !acc_mask[0])
            begin
                acc_volt[0] = mv;
                acc_mask[0] = 1'b1;
            end
            else if (pred_tick >= SLOT_SECOND_LO && pred_tick <= SLOT_SECOND_HI
                     && !acc_mask[1])
            begin
                acc_volt[1] = mv;
                acc_mask[1] = 1'b1;
            end
            else if (pred_tick > SLOT_SECOND_HI)
            begin
                acc_volt[2] = mv;
                acc_mask[2] = 1'b1;
            end
        end

        // Temperature statistics, with the sum held inside its 21-bit range.
        if (tv)
        begin
            next_sum = acc_sum + int'(temp);
            if (next_sum > SUM_HI)
                next_sum = SUM_HI;
            if (next_sum < SUM_LO)
                next_sum = SUM_LO;
            acc_sum   = next_sum;
            acc_count = acc_count + COUNT_W'(1);
            if (int'(temp) < acc_min)
                acc_min = int'(temp);
            if (int'(temp) > acc_max)
                acc_max = int'(temp);
        end

        // Retransmission of the previous record.
        opportunity = pred_tick != 0 && ival != 0 && (pred_tick % ival) == ival - 1;
        if (opportunity && retx_cnt < {1'b0, pred_lim} && vv && mv > pred_thr)
        begin
            made[n] = held_packet(retx_cnt[RNUM_W-1:0]);
            n++;
            retx_cnt = retx_cnt + RCNT_W'(1);
        end

        // Window end: latch the record and send it as transmission 0.
        if (pred_tick >= WINDOW - 1)
        begin
            held_rec.sum         = acc_sum[SUM_W-1:0];
            held_rec.count       = acc_count;
            held_rec.tmin        = acc_min[TEMP_W-1:0];
            held_rec.tmax        = acc_max[TEMP_W-1:0];
            held_rec.mask        = acc_mask;
            held_rec.volt_first  = acc_volt[0];
            held_rec.volt_second = acc_volt[1];
            held_rec.volt_third  = acc_volt[2];
            seq_num  = seq_num + SEQ_W'(1);
            made[n]  = held_packet('0);
            n++;
            retx_cnt = RCNT_W'(1);
            open_window();
            pred_tick = 0;
        end
        else
        begin
            pred_tick = (pred_tick + 1) % 64;
        end

        if (n > 0)
            made[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            pending_packets.push_back(made[i]);
    endtask

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        if (error_count < 50)
            $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("packet %0d field %s: got 0x%0h, expected 0x%0h",
                                      packets_seen, name, got, want));
    endtask

    // Offers one tick after a random gap and waits for its transfer.
    task automatic send_tick(input logic tv, input logic signed [TEMP_W-1:0] temp,
                             input logic vv, input logic [VOLT_W-1:0] mv);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {mv, temp};
        s_axis_tuser  <= {vv, tv};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        aggregate_tick(tv, temp, vv, mv);
        ticks_sent++;
        @(negedge clk);
    endtask

    // Waits until every expected packet has arrived and the block is quiet.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_packets.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_VOLT_THRESHOLD: pred_thr  = val;
            CFG_RETX_INTERVAL:  pred_ival = val[IVAL_W-1:0];
            CFG_RETX_LIMIT:     pred_lim  = val[RNUM_W-1:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        reg_writes++;
    endtask

    // Result receiver: random stalls, plus one long hold-off on request.
    initial
    begin : result_sink
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_req)
            begin
                gap = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (gap != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Compares every packet transfer with the oldest expectation.
    always @(posedge clk)
    begin : packet_check
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            // Output packing, lowest bit first.
            got.last             = m_axis_tlast;
            got.retx_num         = m_axis_tdata[2:0];
            got.packet_seq       = m_axis_tdata[18:3];
            got.rec.sum          = m_axis_tdata[39:19];
            got.rec.count        = m_axis_tdata[45:40];
            got.rec.tmin         = m_axis_tdata[61:46];
            got.rec.tmax         = m_axis_tdata[77:62];
            got.rec.mask         = m_axis_tdata[80:78];
            got.rec.volt_first   = m_axis_tdata[96:81];
            got.rec.volt_second  = m_axis_tdata[112:97];
            got.rec.volt_third   = m_axis_tdata[128:113];
            packets_seen++;
            if (pending_packets.size() == 0)
            begin
                report_mismatch($sformatf("packet %0d arrived with nothing expected",
                                          packets_seen));
            end
            else
            begin
                want = pending_packets.pop_front();
                if (want.retx_num != 0)
                    retx_seen++;
                check_field("last", 32'(got.last), 32'(want.last));
                check_field("retransmission_number", 32'(got.retx_num),
                            32'(want.retx_num));
                check_field("packet_seq", 32'(got.packet_seq), 32'(want.packet_seq));
                check_field("temp_sum", 32'(got.rec.sum), 32'(want.rec.sum));
                check_field("temp_count", 32'(got.rec.count), 32'(want.rec.count));
                check_field("temp_min", 32'(got.rec.tmin), 32'(want.rec.tmin));
                check_field("temp_max", 32'(got.rec.tmax), 32'(want.rec.tmax));
                check_field("voltage_mask", 32'(got.rec.mask), 32'(want.rec.mask));
                check_field("volt_first", 32'(got.rec.volt_first),
                            32'(want.rec.volt_first));
                check_field("volt_second", 32'(got.rec.volt_second),
                            32'(want.rec.volt_second));
                check_field("volt_third", 32'(got.rec.volt_third),
                            32'(want.rec.volt_third));
                check_field("zero fill", 32'(m_axis_tdata[OUT_DATA_W-1:129]), 32'(0));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped at the cycle limit with %0d packets outstanding.",
                     pending_packets.size());
            $display("FAIL sensor_window_aggregator_top");
            $finish;
        end
    end

    // Main stimulus: reset, directed table, random phases, final drain.
    initial
    begin : stimulus
        step_row_t              row;
        result_t                typed;
        int                     phase;
        int                     len;
        int                     near;
        bit                     pressure;
        logic [2:0]             wr_sel;
        logic [VOLT_W-1:0]      thr_val;
        logic [IVAL_W-1:0]      ival_val;
        logic [RNUM_W-1:0]      lim_val;
        logic [CFG_DATA_W-1:0]  cfg_val;
        logic                   tv;
        logic                   vv;
        logic signed [TEMP_W-1:0] temp;
        logic [VOLT_W-1:0]      mv;

        // Predictor starts from the reset state.
        pred_thr  = VOLT_THRESHOLD_RST;
        pred_ival = RETX_INTERVAL_RST;
        pred_lim  = RETX_LIMIT_RST;
        pred_tick = 0;
        open_window();
        held_rec  = '0;
        retx_cnt  = RCNT_W'(RETX_LIMIT_RST) + RCNT_W'(1);
        seq_num   = '0;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part.
        foreach (dir_table[r])
        begin
            row = dir_table[r];
            if (row.kind == ROW_CFG)
            begin
                settle();
                write_reg(row.cidx, CFG_DATA_W'(row.cval));
            end
            else
            begin
                for (int k = 0; k < row.reps; k++)
                    send_tick(1'(row.tv), TEMP_W'(row.temp), 1'(row.vv), VOLT_W'(row.mv));
                // The hand-written record replaces the predicted one.
                if (row.kind == ROW_CHECKED)
                begin
                    typed.last            = 1'b1;
                    typed.retx_num        = '0;
                    typed.packet_seq      = SEQ_W'(row.e_seq);
                    typed.rec.sum         = SUM_W'(row.e_sum);
                    typed.rec.count       = COUNT_W'(row.e_cnt);
                    typed.rec.tmin        = TEMP_W'(row.e_min);
                    typed.rec.tmax        = TEMP_W'(row.e_max);
                    typed.rec.mask        = MASK_W'(row.e_mask);
                    typed.rec.volt_first  = VOLT_W'(row.e_v1);
                    typed.rec.volt_second = VOLT_W'(row.e_v2);
                    typed.rec.volt_third  = VOLT_W'(row.e_v3);
                    pending_packets[pending_packets.size() - 1] = typed;
                end
            end
        end

        // Random phases, each under its own register setting.
        phase = 0;
        while (ticks_sent < TICKS_TARGET)
        begin
            settle();
            pressure = (phase == PRESSURE_PHASE);
            calm = pressure || ($urandom_range(0, 4) == 0);
            wr_sel = 3'b111;
            case (phase)
                0:
                begin
                    thr_val = '0;
                    ival_val = 5'd1;
                    lim_val = 3'd0;
                end
                1:
                begin
                    thr_val = 16'hFFFF;
                    ival_val = 5'd30;
                    lim_val = 3'd7;
                end
                2:
                begin
                    thr_val = VOLT_THRESHOLD_RST;
                    ival_val = 5'd31;
                    lim_val = 3'd1;
                end
                PRESSURE_PHASE:
                begin
                    thr_val = '0;
                    ival_val = 5'd1;
                    lim_val = 3'd7;
                end
                default:
                begin
                    wr_sel = 3'($urandom_range(1, 7));
                    case ($urandom_range(0, 4))
                        0: thr_val = '0;
                        1: thr_val = 16'hFFFF;
                        2: thr_val = VOLT_THRESHOLD_RST;
                        default: thr_val = VOLT_W'($urandom());
                    endcase
                    ival_val = IVAL_W'(ival_picks[$urandom_range(0, 9)]);
                    lim_val = RNUM_W'($urandom_range(0, 7));
                end
            endcase

            // Narrow registers get random upper bits, which must be ignored.
            if (wr_sel[0])
                write_reg(CFG_VOLT_THRESHOLD, thr_val);
            if (wr_sel[1])
            begin
                cfg_val = CFG_DATA_W'($urandom());
                cfg_val[IVAL_W-1:0] = ival_val;
                write_reg(CFG_RETX_INTERVAL, cfg_val);
            end
            if (wr_sel[2])
            begin
                cfg_val = CFG_DATA_W'($urandom());
                cfg_val[RNUM_W-1:0] = lim_val;
                write_reg(CFG_RETX_LIMIT, cfg_val);
            end

            // Under pressure the receiver stops for a long time while ticks keep coming.
            if (pressure)
                hold_req = 1'b1;
            len = pressure ? 80 : $urandom_range(20, 90);

            for (int k = 0; k < len; k++)
            begin
                tv = ($urandom_range(0, 4) != 0);
                case ($urandom_range(0, 7))
                    0: temp = 16'sh7FFF;
                    1: temp = 16'sh8000;
                    2, 3: temp = TEMP_W'($urandom_range(0, 400) - 200);
                    default: temp = TEMP_W'($urandom());
                endcase
                vv = pressure || ($urandom_range(0, 9) < 7);
                case ($urandom_range(0, 5))
                    0: mv = '0;
                    1: mv = 16'hFFFF;
                    2, 3:
                    begin
                        near = int'(pred_thr) + int'($urandom_range(0, 4)) - 2;
                        if (near < 0)
                            near = 0;
                        if (near > 65535)
                            near = 65535;
                        mv = VOLT_W'(near);
                    end
                    default: mv = VOLT_W'($urandom());
                endcase
                if (pressure && mv == 0)
                    mv = 16'd1;
                send_tick(tv, temp, vv, mv);
            end
            phase++;
        end

        calm = 1'b0;
        settle();

        $display("Run covered %0d ticks in %0d random phases with %0d register writes.",
                 ticks_sent, phase, reg_writes);
        $display("Checked %0d packets, %0d of them retransmissions; %0d mismatches.",
                 packets_seen, retx_seen, error_count);
        if (error_count == 0)
            $display("PASS sensor_window_aggregator_top");
        else
            $display("FAIL sensor_window_aggregator_top");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/swa_pkg.sv
rtl/core/swa_window.sv
rtl/core/swa_sched.sv
rtl/core/swa_out_fifo.sv
rtl/core/sensor_window_aggregator_top.sv
verif/sensor_window_aggregator_top_tb.sv
